// ----- hw/rtl/bdq_pkg.sv -----
// Shared types and codes for the bounded deque with search.
package bdq_pkg;

   typedef enum logic [2:0] {
      FUNC_ADD_FRONT = 3'd0,
      FUNC_ADD_BACK  = 3'd1,
      FUNC_REM_FRONT = 3'd2,
      FUNC_REM_BACK  = 3'd3,
      FUNC_CONTAINS  = 3'd4,
      FUNC_REM_ALL   = 3'd5
   } func_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Classified command handed from the front end to the execution engine.
   typedef struct packed {
      logic [2:0] func;
      logic       is_add;
      logic       is_end_rem;
      logic       is_scan;
   } cmd_type;

endpackage

// ----- hw/rtl/bdq_front.sv -----
// Front end: accepts request words, classifies them and holds them in a short queue.
module bdq_front #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_func,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                        cmd_valid,
   input  logic                        cmd_take,
   output bdq_pkg::cmd_type            cmd,
   output logic [VALUE_WIDTH-1:0]      cmd_value
);

   // Two-entry queue
   bdq_pkg::cmd_type          q_cmd_ff [2];
   logic [VALUE_WIDTH-1:0]    q_val_ff [2];
   logic                      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]                fill_ff, fill_in;
   logic                      push, pop;
   bdq_pkg::cmd_type          cls;

   always_comb begin
      cls.func       = req_func;
      cls.is_add     = (req_func == bdq_pkg::FUNC_ADD_FRONT) ||
                       (req_func == bdq_pkg::FUNC_ADD_BACK);
      cls.is_end_rem = (req_func == bdq_pkg::FUNC_REM_FRONT) ||
                       (req_func == bdq_pkg::FUNC_REM_BACK);
      cls.is_scan    = (req_func == bdq_pkg::FUNC_CONTAINS) ||
                       (req_func == bdq_pkg::FUNC_REM_ALL);
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = q_cmd_ff[rd_ptr_ff];
   assign cmd_value = q_val_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) fill_in = fill_ff + 2'd1;
      else if (pop && !push) fill_in = fill_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_cmd_ff[wr_ptr_ff] <= cls;
         q_val_ff[wr_ptr_ff] <= req_value;
      end
   end

endmodule

// ----- hw/rtl/bdq_back.sv -----
// Execution engine: circular store, end operations and the compacting scan.
module bdq_back #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_take,
   input  bdq_pkg::cmd_type             cmd,
   input  logic [VALUE_WIDTH-1:0]       cmd_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [31:0]           rsp_front_value,
   output logic signed [31:0]           rsp_back_value,
   output logic [4:0]                   rsp_entry_count,
   output logic                         rsp_is_empty,
   output logic                         rsp_found,
   output logic [1:0]                   rsp_status
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_RDF   = 6'b000100,
      ST_RDB   = 6'b001000,
      ST_WAITB = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [VALUE_WIDTH-1:0]  mem [DEPTH];
   logic [VALUE_WIDTH-1:0]  rd_data_ff;
   logic [IW-1:0]           front_ff, front_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           scan_ff, scan_in, kept_ff, kept_in;
   logic                    found_ff, found_in;
   logic [1:0]              status_ff, status_in;
   logic [VALUE_WIDTH-1:0]  key_ff, key_in;
   logic                    rem_all_ff, rem_all_in;
   logic                    pend_ff, pend_in;     // a read issued last cycle
   logic [IW-1:0]           rd_addr;
   logic                    rd_en;
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   logic [VALUE_WIDTH-1:0]  wr_data;
   logic [VALUE_WIDTH-1:0]  fv_ff, fv_in, bv_ff, bv_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]           slot_scan, slot_kept, slot_back, slot_prev;

   // base + off modulo DEPTH; the sum stays below 3 * DEPTH, so two
   // conditional subtractions bring it into range.
   function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [IW+CW:0] s;
      s = (IW+CW+1)'(base) + (IW+CW+1)'(off);
      if (s >= (IW+CW+1)'(DEPTH)) s = s - (IW+CW+1)'(DEPTH);
      if (s >= (IW+CW+1)'(DEPTH)) s = s - (IW+CW+1)'(DEPTH);
      return IW'(s);
   endfunction

   function automatic logic signed [31:0] ext(input logic [VALUE_WIDTH-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[31:0];
   endfunction

   assign slot_scan = wrap(front_ff, scan_ff);
   assign slot_kept = wrap(front_ff, kept_ff);
   assign slot_back = wrap(front_ff, count_ff - CW'(1));
   assign slot_prev = wrap(front_ff, DEPTH_C - CW'(1));

   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid;

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      kept_in      = kept_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      key_in       = key_ff;
      rem_all_in   = rem_all_ff;
      pend_in      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = slot_scan;
      wr_en        = 1'b0;
      wr_addr      = slot_kept;
      wr_data      = cmd_value;
      fv_in        = fv_ff;
      bv_in        = bv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               found_in   = 1'b0;
               status_in  = bdq_pkg::STATUS_OK;
               key_in     = cmd_value;
               rem_all_in = (cmd.func == bdq_pkg::FUNC_REM_ALL);
               scan_in    = '0;
               kept_in    = '0;
               state_in   = ST_RDF;
               if (cmd.is_add) begin
                  if (count_ff >= DEPTH_C) status_in = bdq_pkg::STATUS_FULL;
                  else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                     if (cmd.func == bdq_pkg::FUNC_ADD_FRONT) begin
                        front_in = slot_prev;
                        wr_addr  = slot_prev;
                     end else begin
                        wr_addr  = wrap(front_ff, count_ff);
                     end
                  end
               end else if (cmd.is_end_rem) begin
                  if (count_ff == '0) status_in = bdq_pkg::STATUS_EMPTY;
                  else begin
                     count_in = count_ff - CW'(1);
                     if (cmd.func == bdq_pkg::FUNC_REM_FRONT)
                        front_in = wrap(front_ff, CW'(1));
                  end
               end else if (cmd.is_scan) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // One entry read per cycle; data compared the following cycle.
            if (pend_ff) begin
               if (rd_data_ff == key_ff) found_in = 1'b1;
               else if (rem_all_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = slot_kept;
                  wr_data = rd_data_ff;
                  kept_in = kept_ff + CW'(1);
               end
            end
            if (scan_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = slot_scan;
               pend_in = 1'b1;
               scan_in = scan_ff + CW'(1);
            end else if (!pend_ff) begin
               if (rem_all_ff) count_in = kept_ff;
               state_in = ST_RDF;
            end
         end
         ST_RDF: begin
            rd_en    = 1'b1;
            rd_addr  = front_ff;
            state_in = ST_RDB;
         end
         ST_RDB: begin
            rd_en    = 1'b1;
            rd_addr  = slot_back;
            fv_in    = rd_data_ff;
            state_in = ST_WAITB;
         end
         ST_WAITB: begin
            bv_in    = rd_data_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      kept_ff    <= kept_in;
      found_ff   <= found_in;
      status_ff  <= status_in;
      key_ff     <= key_in;
      rem_all_ff <= rem_all_in;
      pend_ff    <= pend_in;
      fv_ff      <= fv_in;
      bv_ff      <= bv_in;
   end

   // Store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // Output word register, loaded when the result is launched.
   logic signed [31:0] o_fv_ff, o_bv_ff;
   logic [4:0]         o_cnt_ff;
   logic               o_found_ff;
   logic [1:0]         o_status_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_RESP && (!rsp_valid_ff || !rsp_stall)) begin
         o_fv_ff     <= (count_ff == '0) ? '0 : ext(fv_ff);
         o_bv_ff     <= (count_ff == '0) ? '0 : ext(bv_ff);
         o_cnt_ff    <= 5'(count_ff);
         o_found_ff  <= found_ff;
         o_status_ff <= status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = o_fv_ff;
   assign rsp_back_value  = o_bv_ff;
   assign rsp_entry_count = o_cnt_ff;
   assign rsp_is_empty    = (o_cnt_ff == 5'd0);
   assign rsp_found       = o_found_ff;
   assign rsp_status      = o_status_ff;

endmodule

// ----- hw/rtl/bounded_deque_with_search.sv -----
// Top level of the bounded deque with search.
// Bounded double-ended queue of signed values held in a DEPTH-entry circular
// store. Each request word adds at the front or back, removes an end entry,
// searches for a value or removes every equal entry while keeping order; each
// yields exactly one response word with the front and back values (0 when
// empty), the count, an empty flag, the found flag and a status. Add and end
// removals read the front and back entries and then respond; contains and remove
// all first walk the store through its single read port, one entry per cycle,
// before doing the same. A two-word request queue lets new requests be taken
// while the engine works and while a response is stalled.
module bounded_deque_with_search #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_func,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_front_value,
   output logic signed [31:0]            rsp_back_value,
   output logic [4:0]                    rsp_entry_count,
   output logic                          rsp_is_empty,
   output logic                          rsp_found,
   output logic [1:0]                    rsp_status
);

   logic                    cmd_valid, cmd_take;
   bdq_pkg::cmd_type        cmd;
   logic [VALUE_WIDTH-1:0]  cmd_value;

   bdq_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_value,
      .cmd_valid, .cmd_take, .cmd, .cmd_value
   );

   bdq_back #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd, .cmd_value,
      .rsp_valid, .rsp_stall, .rsp_front_value, .rsp_back_value,
      .rsp_entry_count, .rsp_is_empty, .rsp_found, .rsp_status
   );

   // A response word never reports more entries than the store holds.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_entry_count) <= DEPTH))
      else $error("count above depth");

   // Full status only when the store is full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bdq_pkg::STATUS_FULL) |->
      (32'(rsp_entry_count) == DEPTH))
      else $error("full status with room left");

   // Empty status only comes with an empty store.
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bdq_pkg::STATUS_EMPTY) |-> rsp_is_empty)
      else $error("empty status with entries held");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the bounded deque with search.
`timescale 1ns / 1ps

module testbench;

   localparam int DEPTH = 16;
   localparam int N_RAND = 1500;

   // Spare function codes: no operation.
   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic [4:0]         entry_count;
      logic               is_empty;
      logic               found;
      logic [1:0]         status;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_func = '0;
   logic signed [31:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_front_value, rsp_back_value;
   logic [4:0] rsp_entry_count;
   logic rsp_is_empty, rsp_found;
   logic [1:0] rsp_status;

   bounded_deque_with_search u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_func), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_front_value(rsp_front_value), .rsp_back_value(rsp_back_value),
      .rsp_entry_count(rsp_entry_count), .rsp_is_empty(rsp_is_empty),
      .rsp_found(rsp_found), .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // Shadow deque: kept in order, front at index 0.
   logic signed [31:0] shadow_q[$];
   req_word_type  pending_reqs[$];
   rsp_word_type  expected_rsps[$];
   int  errors = 0;
   bit  calm = 0;       // no idling in the last part of the run
   int  hold_cycles = 0; // long receiver hold-off, counted in the monitor

   // Apply one request word to the shadow deque and return the response.
   function automatic rsp_word_type deque_apply(req_word_type w);
      rsp_word_type r;
      logic signed [31:0] kept[$];
      r = '0;
      r.status = bdq_pkg::STATUS_OK;
      case (w.func)
         bdq_pkg::FUNC_ADD_FRONT: begin
            if (shadow_q.size() >= DEPTH) r.status = bdq_pkg::STATUS_FULL;
            else shadow_q.push_front(w.value);
         end
         bdq_pkg::FUNC_ADD_BACK: begin
            if (shadow_q.size() >= DEPTH) r.status = bdq_pkg::STATUS_FULL;
            else shadow_q.push_back(w.value);
         end
         bdq_pkg::FUNC_REM_FRONT: begin
            if (shadow_q.size() == 0) r.status = bdq_pkg::STATUS_EMPTY;
            else void'(shadow_q.pop_front());
         end
         bdq_pkg::FUNC_REM_BACK: begin
            if (shadow_q.size() == 0) r.status = bdq_pkg::STATUS_EMPTY;
            else void'(shadow_q.pop_back());
         end
         bdq_pkg::FUNC_CONTAINS: begin
            foreach (shadow_q[i]) if (shadow_q[i] == w.value) r.found = 1'b1;
         end
         bdq_pkg::FUNC_REM_ALL: begin
            foreach (shadow_q[i]) begin
               if (shadow_q[i] == w.value) r.found = 1'b1;
               else kept.push_back(shadow_q[i]);
            end
            shadow_q = kept;
         end
         default: ;
      endcase
      r.entry_count = 5'(shadow_q.size());
      r.is_empty = (shadow_q.size() == 0);
      if (shadow_q.size() != 0) begin
         r.front_value = shadow_q[0];
         r.back_value = shadow_q[shadow_q.size()-1];
      end
      return r;
   endfunction

   // Driver: offers words from pending_reqs, idles in random bursts.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(deque_apply(pending_reqs.pop_front()));
         end
         // Load the next word only once the current one is gone.
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 9) - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               req_func <= pending_reqs[0].func;
               req_value <= pending_reqs[0].value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted response with the oldest expectation.
   int stall_left = 0;
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_front_value !== e.front_value) begin
                  $error("front_value exp %0d got %0d", e.front_value, rsp_front_value);
                  errors++;
               end
               if (rsp_back_value !== e.back_value) begin
                  $error("back_value exp %0d got %0d", e.back_value, rsp_back_value);
                  errors++;
               end
               if (rsp_entry_count !== e.entry_count) begin
                  $error("entry_count exp %0d got %0d", e.entry_count, rsp_entry_count);
                  errors++;
               end
               if (rsp_is_empty !== e.is_empty) begin
                  $error("is_empty exp %0d got %0d", e.is_empty, rsp_is_empty);
                  errors++;
               end
               if (rsp_found !== e.found) begin
                  $error("found exp %0d got %0d", e.found, rsp_found);
                  errors++;
               end
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status);
                  errors++;
               end
            end
         end
         // Receiver idling: a long hold-off on request, else random bursts.
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic signed [31:0] pick_value();
      // Small pool so searches hit; occasionally the extremes or fully random.
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return $urandom();
         default: return $urandom_range(0, 7) - 3;
      endcase
   endfunction

   task automatic queue_req(input logic [2:0] f, input logic signed [31:0] v);
      req_word_type w;
      w.func = f;
      w.value = v;
      pending_reqs.push_back(w);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
   endtask

   initial begin
      int f;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-queue cases, extremes, fill past full, remove all.
      queue_req(bdq_pkg::FUNC_REM_FRONT, 0);
      queue_req(bdq_pkg::FUNC_REM_BACK, -1);
      queue_req(bdq_pkg::FUNC_CONTAINS, 5);
      queue_req(bdq_pkg::FUNC_REM_ALL, 5);
      queue_req(FUNC_SPARE_LO, 1);
      queue_req(FUNC_SPARE_HI, 2);
      queue_req(bdq_pkg::FUNC_ADD_FRONT, 32'sh8000_0000);
      queue_req(bdq_pkg::FUNC_ADD_BACK, 32'sh7FFF_FFFF);
      queue_req(bdq_pkg::FUNC_CONTAINS, 32'sh7FFF_FFFF);
      queue_req(bdq_pkg::FUNC_REM_ALL, 9);
      for (int i = 0; i < 14; i++)
         queue_req(i[0] ? bdq_pkg::FUNC_ADD_FRONT : bdq_pkg::FUNC_ADD_BACK, i % 3);
      queue_req(bdq_pkg::FUNC_ADD_BACK, -1);   // full: dropped
      queue_req(bdq_pkg::FUNC_ADD_FRONT, -1);  // full: dropped
      queue_req(bdq_pkg::FUNC_REM_ALL, 1);
      queue_req(bdq_pkg::FUNC_REM_FRONT, 0);
      queue_req(bdq_pkg::FUNC_REM_BACK, 0);

      // Long hold-off at the receiver while requests keep coming.
      hold_cycles = 300;
      wait_drained();

      // Random: weighted toward adds so the deque fills and drains.
      for (int i = 0; i < N_RAND; i++) begin
         if (i == N_RAND - 200) begin
            wait_drained();
            calm = 1;
         end
         f = $urandom_range(0, 19);
         if (f < 7) queue_req(bdq_pkg::FUNC_ADD_BACK, pick_value());
         else if (f < 11) queue_req(bdq_pkg::FUNC_ADD_FRONT, pick_value());
         else if (f < 13) queue_req(bdq_pkg::FUNC_REM_FRONT, $urandom());
         else if (f < 15) queue_req(bdq_pkg::FUNC_REM_BACK, $urandom());
         else if (f < 17) queue_req(bdq_pkg::FUNC_CONTAINS, pick_value());
         else if (f < 19) queue_req(bdq_pkg::FUNC_REM_ALL, pick_value());
         else queue_req(($urandom_range(0, 1) == 0) ? FUNC_SPARE_LO : FUNC_SPARE_HI,
                        $urandom());
         if (pending_reqs.size() > 8) wait_drained();
      end
      wait_drained();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end
endmodule
